// File: design/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap queue: entry widths,
// operation and status codes, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int KEY_W    = 32;
    localparam int PAY_W    = 16;
    localparam int ENT_W    = KEY_W + PAY_W;
    localparam int STATUS_W = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHECK,
        S_UP_CMP,
        S_POP_TAKE,
        S_DN_CHECK,
        S_DN_CMP,
        S_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    ins_start;
        logic    pop_start;
        logic    pop_take;
        logic    rd_parent;
        logic    rd_kids;
        logic    wr_entry;
        logic    move_up;
        logic    move_down;
        logic    set_status;
        status_t status_code;
        logic    load_result;
    } dp_cmd_t;

    // Conditions reported by the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic count_zero;
        logic parent_greater;
        logic has_left;
        logic child_less;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/bmhq_req_if.sv
// ----------------------------------------------------------------------------
// bmhq_req_if
// Request channel of the heap queue: valid, ready, operation, key and payload.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
    import bmhq_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [KEY_W-1:0] key_in;
    logic [PAY_W-1:0] payload_in;

    modport source (output valid, output op, output key_in, output payload_in,
                    input ready);
    modport sink   (input valid, input op, input key_in, input payload_in,
                    output ready);
endinterface

// File: design/bmhq_res_if.sv
// ----------------------------------------------------------------------------
// bmhq_res_if
// Result channel of the heap queue: valid, ready, status, popped key and
// payload, and the occupancy after the operation.
// ----------------------------------------------------------------------------
interface bmhq_res_if #(
    parameter int DEPTH = 256
);
    import bmhq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key_out;
    logic [PAY_W-1:0]    payload_out;
    logic [CNT_W-1:0]    occupancy;

    modport source (output valid, output status, output key_out, output payload_out,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input key_out, input payload_out,
                    input occupancy, output ready);
endinterface

// File: design/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic memory with one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter  int WIDTH  = 48,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [WIDTH-1:0]  rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: design/bmhq_dp.sv
// ----------------------------------------------------------------------------
// bmhq_dp
// Datapath of the heap queue: entry count, hole position, the entry being
// sifted, the heap memory, key comparators and the result register.
// ----------------------------------------------------------------------------
module bmhq_dp #(
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bmhq_pkg::dp_cmd_t            cmd,
    output bmhq_pkg::dp_stat_t           stat,
    input  logic [bmhq_pkg::KEY_W-1:0]   key_in,
    input  logic [bmhq_pkg::PAY_W-1:0]   payload_in,
    input  logic                         res_ready,
    output logic                         res_valid,
    output logic [bmhq_pkg::STATUS_W-1:0] res_status,
    output logic [bmhq_pkg::KEY_W-1:0]   res_key,
    output logic [bmhq_pkg::PAY_W-1:0]   res_payload,
    output logic [CNT_W-1:0]             res_occupancy
);
    import bmhq_pkg::*;

    localparam int KID_W = ADDR_W + 2;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ENT_W-1:0]  ent_reg, ent_next;
    logic [ENT_W-1:0]  popped_reg, popped_next;
    status_t           pend_status_reg, pend_status_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [ENT_W-1:0]  out_ent_reg, out_ent_next;
    logic [CNT_W-1:0]  out_occ_reg, out_occ_next;

    logic [CNT_W-1:0]  count_m1;
    logic [ADDR_W-1:0] parent_idx;
    logic [KID_W-1:0]  left_idx;
    logic [KID_W-1:0]  right_idx;
    logic [KID_W-1:0]  count_ext;
    logic              has_left;
    logic              has_right;
    logic              right_wins;
    logic [ENT_W-1:0]  child_ent;
    logic [ADDR_W-1:0] child_idx;

    logic              ram_we;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [ENT_W-1:0]  rd_a;
    logic [ENT_W-1:0]  rd_b;

    // Heap index arithmetic. Entries are packed as {key, payload}.
    assign count_m1   = count_reg - CNT_W'(1);
    assign parent_idx = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + KID_W'(1);
    assign count_ext  = KID_W'(count_reg);
    assign has_left   = left_idx < count_ext;
    assign has_right  = right_idx < count_ext;

    // On equal keys the left child wins.
    assign right_wins = has_right && (rd_b[ENT_W-1 -: KEY_W] < rd_a[ENT_W-1 -: KEY_W]);
    assign child_ent  = right_wins ? rd_b : rd_a;
    assign child_idx  = right_wins ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

    assign ram_we      = cmd.wr_entry | cmd.move_up | cmd.move_down;
    assign ram_wdata   = cmd.move_up   ? rd_a :
                         cmd.move_down ? child_ent : ent_reg;
    assign ram_raddr_a = cmd.pop_start ? '0 :
                         cmd.rd_parent ? parent_idx :
                         cmd.rd_kids   ? left_idx[ADDR_W-1:0] : pos_reg;
    assign ram_raddr_b = cmd.pop_start ? count_m1[ADDR_W-1:0] : right_idx[ADDR_W-1:0];

    bmhq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (pos_reg),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (rd_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        stat.full           = count_reg == CNT_W'(DEPTH);
        stat.empty          = count_reg == '0;
        stat.pos_zero       = pos_reg == '0;
        stat.count_zero     = count_reg == '0;
        stat.parent_greater = rd_a[ENT_W-1 -: KEY_W] > ent_reg[ENT_W-1 -: KEY_W];
        stat.has_left       = has_left;
        stat.child_less     = child_ent[ENT_W-1 -: KEY_W] < ent_reg[ENT_W-1 -: KEY_W];
        stat.out_free       = !out_valid_reg || res_ready;
    end

    always_comb
    begin
        count_next       = count_reg;
        pos_next         = pos_reg;
        ent_next         = ent_reg;
        popped_next      = popped_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_ent_next     = out_ent_reg;
        out_occ_next     = out_occ_reg;

        if (cmd.ins_start)
        begin
            ent_next   = {key_in, payload_in};
            pos_next   = count_reg[ADDR_W-1:0];
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop_start)
        begin
            count_next = count_m1;
        end
        if (cmd.pop_take)
        begin
            popped_next = rd_a;
            ent_next    = rd_b;
            pos_next    = '0;
        end
        if (cmd.move_up)
        begin
            pos_next = parent_idx;
        end
        if (cmd.move_down)
        begin
            pos_next = child_idx;
        end
        if (cmd.set_status)
        begin
            pend_status_next = cmd.status_code;
        end

        if (cmd.load_result)
        begin
            out_valid_next  = 1'b1;
            out_status_next = pend_status_reg;
            out_ent_next    = (pend_status_reg == ST_POPPED) ? popped_reg : '0;
            out_occ_next    = count_reg;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        ent_reg         <= ent_next;
        popped_reg      <= popped_next;
        pend_status_reg <= pend_status_next;
        out_status_reg  <= out_status_next;
        out_ent_reg     <= out_ent_next;
        out_occ_reg     <= out_occ_next;
    end

    assign res_valid     = out_valid_reg;
    assign res_status    = out_status_reg;
    assign res_key       = out_ent_reg[ENT_W-1 -: KEY_W];
    assign res_payload   = out_ent_reg[PAY_W-1:0];
    assign res_occupancy = out_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds heap depth");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_entry, cmd.move_up, cmd.move_down}))
        else $error("more than one heap write source selected");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_start |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not decrement entry count");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// File: design/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Controller of the heap queue: takes a request, steps the sift up or sift
// down one level at a time, in a check state and a compare state, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_op,
    output logic               req_ready,
    input  bmhq_pkg::dp_stat_t stat,
    output bmhq_pkg::dp_cmd_t  cmd
);
    import bmhq_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_op == OP_INSERT && !stat.full)
                    begin
                        state_next = S_UP_CHECK;
                    end
                    else if (req_op == OP_POP && !stat.empty)
                    begin
                        state_next = S_POP_TAKE;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_UP_CHECK: state_next = stat.pos_zero ? S_RESULT : S_UP_CMP;
            S_UP_CMP:   state_next = stat.parent_greater ? S_UP_CHECK : S_RESULT;
            S_POP_TAKE: state_next = stat.count_zero ? S_RESULT : S_DN_CHECK;
            S_DN_CHECK: state_next = stat.has_left ? S_DN_CMP : S_RESULT;
            S_DN_CMP:   state_next = stat.child_less ? S_DN_CHECK : S_RESULT;
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.set_status = 1'b1;
                    if (req_op == OP_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.status_code = ST_INSERTED;
                            cmd.ins_start   = 1'b1;
                        end
                    end
                    else
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.status_code = ST_POPPED;
                            cmd.pop_start   = 1'b1;
                        end
                    end
                end
            end
            S_UP_CHECK:
            begin
                cmd.wr_entry  = stat.pos_zero;
                cmd.rd_parent = !stat.pos_zero;
            end
            S_UP_CMP:
            begin
                cmd.move_up  = stat.parent_greater;
                cmd.wr_entry = !stat.parent_greater;
            end
            S_POP_TAKE:
            begin
                cmd.pop_take = 1'b1;
            end
            S_DN_CHECK:
            begin
                cmd.rd_kids  = stat.has_left;
                cmd.wr_entry = !stat.has_left;
            end
            S_DN_CMP:
            begin
                cmd.move_down = stat.child_less;
                cmd.wr_entry  = !stat.child_less;
            end
            S_RESULT:
            begin
                cmd.load_result = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> state_reg != S_IDLE)
        else $error("accepted request left the controller idle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> stat.out_free)
        else $error("result loaded over an untaken result");

endmodule

// File: design/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Fixed-depth binary min-heap priority queue of key and payload entries.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake     Payload
//  request   in   valid/ready   op, key_in, payload_in
//  result    out  valid/ready   status, key_out, payload_out, occupancy
//
// One request is worked at a time. An insert or pop sifts through the heap
// before its result is loaded, and the next request is taken once the result
// is loaded; a full or empty case goes straight to the result state. The sift
// loop issues the heap memory reads for a level in a check state, then
// compares and writes back in a compare state. Reset clears the entry count
// and the result valid flag; the heap memory needs no clearing, since only
// entries below the count are read.
// A result waits in its output register while the next request is taken.
// ----------------------------------------------------------------------------
//
// The heap is kept with a hole rather than with swaps: the entry being placed
// stays in a register, and each level moves one parent (sift up) or one
// child (sift down) into the hole, so each level costs one memory write.
// Sift down reads both children at once through the second read port; on
// equal keys the left child is chosen, and a child only moves up when its
// key is strictly smaller than the entry being placed. Sift up stops as soon
// as the parent key is not strictly greater. A pop reads the root and the
// last entry in the same cycle, returns the root and sifts the last entry
// down from the root. Inserts on a full heap and pops on an empty heap
// change nothing and report their own status codes.
module binary_min_heap_queue #(
    parameter  int DEPTH = 256,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic      clk,
    input  logic      rst_n,
    bmhq_req_if.sink  request,
    bmhq_res_if.source result
);
    import bmhq_pkg::*;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic             req_ready;
    logic             res_valid;
    logic [STATUS_W-1:0] res_status;
    logic [KEY_W-1:0] res_key;
    logic [PAY_W-1:0] res_payload;
    logic [CNT_W-1:0] res_occupancy;

    // The controller owns the request handshake and sequences the sift.
    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_op    (request.op),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the heap memory, the count and the result register.
    bmhq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .key_in        (request.key_in),
        .payload_in    (request.payload_in),
        .res_ready     (result.ready),
        .res_valid     (res_valid),
        .res_status    (res_status),
        .res_key       (res_key),
        .res_payload   (res_payload),
        .res_occupancy (res_occupancy)
    );

    assign request.ready      = req_ready;
    assign result.valid       = res_valid;
    assign result.status      = res_status;
    assign result.key_out     = res_key;
    assign result.payload_out = res_payload;
    assign result.occupancy   = res_occupancy;

endmodule

// File: tb/binary_min_heap_queue_tb.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb
// Self-checking bench for the heap queue. Requests go in through the request
// channel with bursty timing, and the result channel is drained with its own
// stall pattern. A heap model inside the bench predicts every result.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam int DEPTH          = 256;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS   = 170;
    localparam int RESET_CYCLES   = 6;
    // A single insert or pop walks at most eight levels, so lingering for
    // DRAIN_CYCLES after the last result is plenty to catch strays.
    localparam int DRAIN_CYCLES   = 60;
    // No handshake for this long means the block has hung. The slowest legal
    // stretch, one operation behind a receiver stall, stays far below this.
    localparam int WATCHDOG_LIMIT = 3000;

    // What the block reports for one request.
    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [CNT_W-1:0] occupancy;
    } heap_result_t;

    logic clk;
    logic rst_n;

    bmhq_req_if                  request_ch ();
    bmhq_res_if #(.DEPTH(DEPTH)) result_ch ();

    binary_min_heap_queue #(.DEPTH(DEPTH)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    // Heap model: the bench keeps its own array of entries and its own count,
    // updated at the moment each request is accepted.
    logic [KEY_W-1:0] heap_keys [DEPTH];
    logic [PAY_W-1:0] heap_tags [DEPTH];
    int               held_count;
    int               peak_count;

    // Results predicted but not yet seen on the result channel, oldest first.
    heap_result_t     expected_results [$];
    heap_result_t     due_result;

    int requests_sent;
    int results_seen;
    int mismatches;
    int data_pops;
    int empty_pops;
    int full_inserts;
    int burst_left;
    int stalled_cycles;

    // Receiver stall pattern state.
    int   rx_mode;
    int   rx_mode_left;
    int   rx_hold_left;
    logic rx_hold_level;

    always #5 clk = ~clk;

    // Every input of the block has a known value from time zero.
    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        request_ch.valid      = 1'b0;
        request_ch.op         = OP_INSERT;
        request_ch.key_in     = '0;
        request_ch.payload_in = '0;
        result_ch.ready       = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Heap model
    // ------------------------------------------------------------------------

    // Applies one request to the model heap and returns the result the block
    // should produce. An insert goes to the end and bubbles up while the
    // parent key is strictly greater. A pop takes the root, moves the last
    // entry to the root and pushes it down toward the smaller child; on a tie
    // between the children the left one is taken, and a child only moves up
    // when it is strictly smaller than the entry being placed.
    function automatic heap_result_t predict_heap_step(op_t op, logic [KEY_W-1:0] key,
                                                       logic [PAY_W-1:0] tag);
        heap_result_t     res;
        int               pos;
        int               up;
        int               left;
        int               right;
        int               best;
        bit               settled;
        logic [KEY_W-1:0] swap_key;
        logic [PAY_W-1:0] swap_tag;

        res = '{status: ST_INSERTED, key: '0, payload: '0, occupancy: '0};
        if (op == OP_INSERT)
        begin
            if (held_count >= DEPTH)
            begin
                // A full heap drops the insert and stays as it is.
                res.status = ST_FULL;
                full_inserts++;
            end
            else
            begin
                pos = held_count;
                heap_keys[pos] = key;
                heap_tags[pos] = tag;
                held_count++;
                settled = 1'b0;
                while (pos != 0 && !settled)
                begin
                    up = (pos - 1) / 2;
                    if (heap_keys[up] <= heap_keys[pos])
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        swap_key       = heap_keys[up];
                        swap_tag       = heap_tags[up];
                        heap_keys[up]  = heap_keys[pos];
                        heap_tags[up]  = heap_tags[pos];
                        heap_keys[pos] = swap_key;
                        heap_tags[pos] = swap_tag;
                        pos = up;
                    end
                end
                res.status = ST_INSERTED;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                res.status = ST_EMPTY;
                empty_pops++;
            end
            else
            begin
                res.status  = ST_POPPED;
                res.key     = heap_keys[0];
                res.payload = heap_tags[0];
                held_count--;
                heap_keys[0] = heap_keys[held_count];
                heap_tags[0] = heap_tags[held_count];
                // Popping the last entry leaves nothing to sift.
                pos     = 0;
                settled = (held_count == 0);
                while (!settled)
                begin
                    left  = 2 * pos + 1;
                    right = 2 * pos + 2;
                    best  = pos;
                    if (left < held_count && heap_keys[left] < heap_keys[best])
                        best = left;
                    if (right < held_count && heap_keys[right] < heap_keys[best])
                        best = right;
                    if (best == pos)
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        swap_key        = heap_keys[best];
                        swap_tag        = heap_tags[best];
                        heap_keys[best] = heap_keys[pos];
                        heap_tags[best] = heap_tags[pos];
                        heap_keys[pos]  = swap_key;
                        heap_tags[pos]  = swap_tag;
                        pos = best;
                    end
                end
                data_pops++;
            end
        end
        if (held_count > peak_count)
            peak_count = held_count;
        res.occupancy = held_count[CNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Sends one item on the request channel and records its predicted result.
    // The sender works in bursts; when a burst runs out, valid drops for a
    // random number of cycles before the next burst starts. Some bursts are
    // long so that there are stretches with no gaps at all.
    task automatic send_heap_op(op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] tag);
        int gap;

        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk) request_ch.valid <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        @(negedge clk);
        request_ch.valid      <= 1'b1;
        request_ch.op         <= op;
        request_ch.key_in     <= key;
        request_ch.payload_in <= tag;
        do
            @(posedge clk);
        while (request_ch.ready !== 1'b1);
        burst_left--;
        requests_sent++;
        expected_results.push_back(predict_heap_step(op, key, tag));
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // The receiver switches between three habits: always ready, ready on a
    // coin toss, and long stalls broken by short ready windows.
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 80);
        end
        rx_mode_left--;
        case (rx_mode)
            0: result_ch.ready <= 1'b1;
            1: result_ch.ready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (rx_hold_left == 0)
                begin
                    rx_hold_level = ~rx_hold_level;
                    rx_hold_left  = rx_hold_level ? $urandom_range(1, 4)
                                                  : $urandom_range(3, 20);
                end
                rx_hold_left--;
                result_ch.ready <= rx_hold_level;
            end
        endcase
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d", result_ch.status);
                mismatches++;
            end
            else
            begin
                due_result = expected_results.pop_front();
                if (result_ch.status !== due_result.status)
                begin
                    $error("status: expected %0d, got %0d", due_result.status,
                           result_ch.status);
                    mismatches++;
                end
                if (result_ch.key_out !== due_result.key)
                begin
                    $error("key_out: expected %h, got %h", due_result.key,
                           result_ch.key_out);
                    mismatches++;
                end
                if (result_ch.payload_out !== due_result.payload)
                begin
                    $error("payload_out: expected %h, got %h", due_result.payload,
                           result_ch.payload_out);
                    mismatches++;
                end
                if (result_ch.occupancy !== due_result.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", due_result.occupancy,
                           result_ch.occupancy);
                    mismatches++;
                end
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((request_ch.valid === 1'b1 && request_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A pop right after reset must report an empty heap.
    task automatic test_pop_on_empty();
        send_heap_op(OP_POP, '1, '1);
    endtask

    // Extreme keys and payloads go in out of order and must come out sorted
    // by key; the final pop finds the heap empty again.
    task automatic test_field_extremes();
        send_heap_op(OP_INSERT, 32'hFFFF_FFFF, 16'h0000);
        send_heap_op(OP_INSERT, 32'h0000_0000, 16'hFFFF);
        send_heap_op(OP_INSERT, 32'h8000_0000, 16'h5555);
        send_heap_op(OP_INSERT, 32'h7FFF_FFFF, 16'hAAAA);
        repeat (5) send_heap_op(OP_POP, '0, '0);
    endtask

    // Equal keys with distinct payloads show that a tie moves no entry. The
    // smaller key in the middle forces a sift through them.
    task automatic test_equal_keys();
        send_heap_op(OP_INSERT, 32'd7, 16'h0001);
        send_heap_op(OP_INSERT, 32'd7, 16'h0002);
        send_heap_op(OP_INSERT, 32'd7, 16'h0003);
        send_heap_op(OP_INSERT, 32'd3, 16'h0004);
        send_heap_op(OP_INSERT, 32'd7, 16'h0005);
        send_heap_op(OP_INSERT, 32'd7, 16'h0006);
        repeat (6) send_heap_op(OP_POP, '0, '0);
    endtask

    // Fills the heap to its depth, checks that further inserts are dropped
    // and refills the one slot a pop frees. The random traffic that follows
    // starts from the full heap.
    task automatic test_fill_to_full();
        while (held_count < DEPTH)
            send_heap_op(OP_INSERT, $urandom_range(0, 2000), 16'($urandom));
        send_heap_op(OP_INSERT, 32'h0000_0000, 16'hFFFF);
        send_heap_op(OP_INSERT, 32'hFFFF_FFFF, 16'h0000);
        send_heap_op(OP_POP, '0, '0);
        send_heap_op(OP_INSERT, 32'h0000_0000, 16'h1234);
        send_heap_op(OP_INSERT, 32'h0000_0001, 16'h4321);
    endtask

    // Random traffic in phases that lean toward inserts, toward pops or
    // neither, so the heap swings between deep and full. Keys come
    // from the full range, from a narrow range that makes ties common, or
    // are the two extremes.
    task automatic test_random_traffic(int item_count);
        int               lean;
        int               phase_left;
        int               pick;
        int               key_kind;
        op_t              op;
        logic [KEY_W-1:0] key;

        phase_left = 0;
        lean       = 0;
        repeat (item_count)
        begin
            if (phase_left == 0)
            begin
                lean       = $urandom_range(0, 2);
                phase_left = $urandom_range(15, 60);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            case (lean)
                0:       op = (pick < 75) ? OP_INSERT : OP_POP;
                1:       op = (pick < 30) ? OP_INSERT : OP_POP;
                default: op = (pick < 50) ? OP_INSERT : OP_POP;
            endcase
            key_kind = $urandom_range(0, 9);
            if (key_kind < 5)
                key = $urandom;
            else if (key_kind < 8)
                key = $urandom_range(0, 15);
            else if (key_kind == 8)
                key = '1;
            else
                key = '0;
            send_heap_op(op, key, 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        held_count     = 0;
        peak_count     = 0;
        requests_sent  = 0;
        results_seen   = 0;
        mismatches     = 0;
        data_pops      = 0;
        empty_pops     = 0;
        full_inserts   = 0;
        burst_left     = 0;
        stalled_cycles = 0;
        rx_mode        = 0;
        rx_mode_left   = 0;
        rx_hold_left   = 0;
        rx_hold_level  = 1'b0;

        // Reset is held low from the start and released on a falling edge.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_pop_on_empty();
        test_field_extremes();
        test_equal_keys();
        test_fill_to_full();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge clk) request_ch.valid <= 1'b0;

        // Wait for every predicted result, then linger to catch any extra one.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d results, heap depth reached %0d of %0d.",
                 requests_sent, results_seen, peak_count, DEPTH);
        $display("Pops with data: %0d, pops on empty: %0d, inserts on full: %0d.",
                 data_pops, empty_pops, full_inserts);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
